// ===== rtl/pcbu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbu_pkg: shared types and helpers for the coefficient bit unpacker
// Payload structs, configuration and job types, status codes and the small
// width decoders that the front and back parts both rely on.
// ----------------------------------------------------------------------------
package pcbu_pkg;

	localparam int ACC_W   = 19;
	localparam int HELD_W  = 5;
	localparam int D_W     = 4;
	localparam int MOD_W   = 13;
	localparam int COEFF_W = 12;
	localparam int IDX_W   = 8;
	localparam int NUM_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_COEFF_BITS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 1'd1;

	localparam logic [D_W-1:0]   COEFF_BITS_RESET = 4'd12;
	localparam logic [MOD_W-1:0] MODULUS_RESET    = 13'd3329;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_WIDTH = 2'd2;

	localparam logic [D_W-1:0] D_1  = 4'd1;
	localparam logic [D_W-1:0] D_4  = 4'd4;
	localparam logic [D_W-1:0] D_5  = 4'd5;
	localparam logic [D_W-1:0] D_10 = 4'd10;
	localparam logic [D_W-1:0] D_11 = 4'd11;
	localparam logic [D_W-1:0] D_12 = 4'd12;

	localparam logic [NUM_W-1:0] MAX_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       start_of_poly;
	} in_item_t;

	typedef struct packed {
		logic [COEFF_W-1:0] coeff_value;
		logic [IDX_W-1:0]   coeff_index;
		logic [1:0]         status;
		logic               sticky_error;
		logic               last_of_byte;
		logic               poly_done;
	} out_item_t;

	typedef struct packed {
		logic [D_W-1:0]   coeff_bits;
		logic [MOD_W-1:0] modulus;
	} cfg_t;

	// One accepted byte as seen by the back part.
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [NUM_W-1:0] count;
		logic             start;
		logic             bad;
	} job_t;

	function automatic logic width_ok(input logic [D_W-1:0] d);
		logic ok;
		ok = 1'b0;
		unique case (d)
			D_1, D_4, D_5, D_10, D_11, D_12: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Coefficients that leave for a given bit count, capped at eight.
	// The count never exceeds 19, so the wide widths yield at most one.
	function automatic logic [NUM_W-1:0] coeff_count(input logic [HELD_W-1:0] h,
			input logic [D_W-1:0] d);
		logic [NUM_W-1:0] n;
		n = '0;
		unique case (d)
			D_1: n = (h >= HELD_W'(8)) ? MAX_PER_BYTE : h[NUM_W-1:0];
			D_4: n = NUM_W'(h >> 2);
			D_5: begin
				if (h >= HELD_W'(15))
					n = 4'd3;
				else if (h >= HELD_W'(10))
					n = 4'd2;
				else if (h >= HELD_W'(5))
					n = 4'd1;
				else
					n = 4'd0;
			end
			D_10, D_11, D_12: n = (h >= HELD_W'(d)) ? 4'd1 : 4'd0;
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [COEFF_W-1:0] coeff_mask(input logic [D_W-1:0] d);
		logic [COEFF_W:0] one_hot;
		one_hot = (COEFF_W+1)'(1) << d;
		return COEFF_W'(one_hot - (COEFF_W+1)'(1));
	endfunction

endpackage

// ===== rtl/pcbu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbu_front: byte intake and bit accumulator
// Merges each accepted byte above the held bits, works out how many
// coefficients it releases and hands a job to the queue.
// ----------------------------------------------------------------------------
module pcbu_front import pcbu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     job_valid,
	input  logic     job_full,
	output job_t     job
);

	logic [ACC_W-1:0]  acc_q;
	logic [HELD_W-1:0] held_q;

	logic [ACC_W-1:0]   base_acc;
	logic [HELD_W-1:0]  base_held;
	logic [ACC_W-1:0]   merged;
	logic [HELD_W-1:0]  held_sum;
	logic [NUM_W-1:0]   n;
	logic [2*D_W-1:0]   used;
	logic [HELD_W-1:0]  used_bits;
	logic               good;
	logic               accept;

	assign in_stall = job_full;
	assign accept   = in_valid && !job_full;
	assign good     = width_ok(cfg.coeff_bits);

	always_comb begin
		base_acc  = in_data.start_of_poly ? '0 : acc_q;
		base_held = in_data.start_of_poly ? '0 : held_q;
		merged    = base_acc | (ACC_W'(in_data.packed_byte) << base_held);
		held_sum  = base_held + HELD_W'(8);
		n         = coeff_count(held_sum, cfg.coeff_bits);
		used      = {{D_W{1'b0}}, n} * {{(D_W){1'b0}}, cfg.coeff_bits};
		used_bits = used[HELD_W-1:0];
	end

	assign job_valid = accept;
	assign job.acc   = merged;
	assign job.count = n;
	assign job.start = in_data.start_of_poly;
	assign job.bad   = !good;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (good) begin
				acc_q  <= merged >> used_bits;
				held_q <= held_sum - used_bits;
			end else begin
				// The byte is dropped; only a start of polynomial clears state.
				acc_q  <= base_acc;
				held_q <= base_held;
			end
		end
	end

endmodule

// ===== rtl/pcbu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbu_queue: two-entry job queue
// Decouples byte intake from coefficient emission so either side can stall.
// ----------------------------------------------------------------------------
module pcbu_queue import pcbu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

endmodule

// ===== rtl/pcbu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbu_back: coefficient extractor
// Takes one job at a time; while the output is not stalled it peels one
// coefficient per cycle off its bits, tracking the polynomial's coefficient index and sticky error.
// ----------------------------------------------------------------------------
module pcbu_back import pcbu_pkg::*; #(
	parameter int COEFFS_PER_POLY = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int CW = $clog2(COEFFS_PER_POLY);

	logic             active_q;
	logic [ACC_W-1:0] acc_q;
	logic [NUM_W-1:0] left_q;
	logic             bad_q;
	logic [CW-1:0]    cnt_q;
	logic             err_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic               emit;
	logic               last;
	logic               load;
	logic [COEFF_W-1:0] value;
	logic               over;
	logic               done;
	logic               err_emit;
	logic [CW-1:0]      cnt_emit;
	logic [CW+7:0]      cnt_wide;

	assign emit     = active_q && (!out_valid_q || !out_stall);
	assign last     = (left_q == NUM_W'(1));
	assign load     = job_valid && (!active_q || (emit && last));
	assign job_pop  = load;

	assign value    = acc_q[COEFF_W-1:0] & coeff_mask(cfg.coeff_bits);
	assign over     = (cfg.coeff_bits == D_12) && ({1'b0, value} >= cfg.modulus);
	assign done     = !bad_q && (cnt_q == CW'(COEFFS_PER_POLY - 1));
	assign err_emit = err_q || bad_q || over;
	assign cnt_wide = {8'd0, cnt_q};

	always_comb begin
		cnt_emit = cnt_q;
		if (!bad_q)
			cnt_emit = (cnt_q == CW'(COEFFS_PER_POLY - 1)) ? '0 : cnt_q + CW'(1);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			acc_q       <= '0;
			left_q      <= '0;
			bad_q       <= 1'b0;
			cnt_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q        <= 1'b1;
				out_q.coeff_value  <= bad_q ? '0 : value;
				out_q.coeff_index  <= cnt_wide[IDX_W-1:0];
				out_q.status       <= bad_q ? ST_WIDTH : (over ? ST_RANGE : ST_OK);
				out_q.sticky_error <= err_emit;
				out_q.last_of_byte <= last;
				out_q.poly_done    <= done;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// A new job may start in the same cycle the previous one finishes.
			if (load) begin
				acc_q    <= job.acc;
				left_q   <= job.bad ? NUM_W'(1) : job.count;
				bad_q    <= job.bad;
				active_q <= job.bad || (job.count != '0);
			end else if (emit) begin
				acc_q  <= acc_q >> cfg.coeff_bits;
				left_q <= left_q - NUM_W'(1);
				if (last)
					active_q <= 1'b0;
			end

			if (load && job.start) begin
				cnt_q <= '0;
				err_q <= 1'b0;
			end else if (emit) begin
				cnt_q <= cnt_emit;
				err_q <= err_emit;
			end
		end
	end

endmodule

// ===== rtl/poly_coeff_bit_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_coeff_bit_unpacker: packed polynomial byte decoder
// Unpacks an LSB-first byte stream into coefficients of 1, 4, 5, 10, 11 or
// 12 bits, with index, last-of-byte mark and range check on 12-bit values.
// ----------------------------------------------------------------------------
// A new byte beat is taken every cycle while the two-entry job queue has
// room; the coefficient extractor then gives one result beat per cycle while
// the output is not stalled, one for each coefficient that a byte releases
// (up to eight at a width of one bit). The next byte's job is loaded in the
// same cycle as the previous byte's last coefficient is emitted, so bytes
// follow each other with no gap. Configuration is sampled live and should
// only be written while no beat is in flight.
module poly_coeff_bit_unpacker import pcbu_pkg::*; #(
	parameter int COEFFS_PER_POLY = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	cfg_t cfg_q;
	logic job_push;
	logic job_full;
	job_t job_in;
	logic job_pop;
	logic job_valid;
	job_t job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff_bits <= COEFF_BITS_RESET;
			cfg_q.modulus    <= MODULUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEFF_BITS: cfg_q.coeff_bits <= cfg_data[D_W-1:0];
				REG_MODULUS:    cfg_q.modulus    <= cfg_data[MOD_W-1:0];
				default: ;
			endcase
		end
	end

	pcbu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.job_valid (job_push),
		.job_full  (job_full),
		.job       (job_in)
	);

	pcbu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_valid (job_valid),
		.pop_job   (job_out)
	);

	pcbu_back #(
		.COEFFS_PER_POLY (COEFFS_PER_POLY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job_out),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
